/* sv/lru_keyed_object_cache_assert.svh */
// assertion macros used by the checker file
`ifndef LRU_KEYED_OBJECT_CACHE_ASSERT_SVH
`define LRU_KEYED_OBJECT_CACHE_ASSERT_SVH

// same-cycle implication
`define LKC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lkc assertion failed");

// next-cycle implication
`define LKC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lkc assertion failed");

`endif

/* sv/lkc_pkg.sv */
`default_nettype none

package lkc_pkg;

    localparam int ENTRIES   = 32;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int LIMIT_RST = (32 > ENTRIES) ? ENTRIES : 32;

    // operation codes
    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [1:0] FUNC_ZERO   = 2'd3;

    // cell commands
    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_SHIFT = 2'd1;
    localparam logic [1:0] CELL_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_LIMIT  = 2'd1;

    typedef struct packed {
        logic [63:0] key_hash;
        logic [11:0] path_length;
        logic [7:0]  backend_id;
        logic [15:0] path_id;
    } t_key;

    typedef struct packed {
        t_key        key;
        logic [15:0] handle;
    } t_entry;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] upto;
        logic [CNT_W-1:0] new_cnt;
        t_entry           front;
    } t_cell_cmd;

    typedef struct packed {
        logic tag_hit;
        logic path_hit;
    } t_cell_match;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] key_hash;
        logic [11:0] path_length;
        logic [7:0]  backend_id;
        logic [15:0] path_id;
        logic [15:0] object_handle;
    } t_in_item;

    typedef struct packed {
        logic        hit;
        logic [15:0] handle_out;
        logic [31:0] hit_count;
        logic [31:0] build_count;
        logic [5:0]  entry_count;
    } t_out_item;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

`default_nettype wire

/* sv/lkc_in_if.sv */
`default_nettype none

interface lkc_in_if;
    logic              valid;
    logic              ready;
    lkc_pkg::t_in_item payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

/* sv/lkc_out_if.sv */
`default_nettype none

interface lkc_out_if;
    logic               valid;
    logic               ready;
    lkc_pkg::t_out_item payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

/* sv/lru_keyed_object_cache.sv */
// channel  | dir | port   | payload
// request  | in  | i_in   | func, key_hash, path_length, backend_id, path_id, object_handle
// response | out | o_out  | hit, handle_out, hit_count, build_count, entry_count
// config   | in  | i_cfg_ | write enable, index, 6-bit data
//
// for each request the transfer edge registers the tag compare in every slot of the
// chain; the update, once not stalled, shifts the chain and loads the response register
// one request in flight; the next is taken while the response still waits
// the update stalls while the response register is full and not being taken
// synchronous active-low reset empties the chain, zeroes counters, enables the cache
// and sets the entry limit to its maximum; no clearing pass is needed
`default_nettype none

module lru_keyed_object_cache (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    lkc_in_if.sink          i_in,
    lkc_out_if.source       o_out,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [5:0] i_cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    localparam int IDX_W = lkc_pkg::IDX_W;
    localparam int CNT_W = lkc_pkg::CNT_W;
    localparam int N     = lkc_pkg::ENTRIES;

    logic               r_state;
    lkc_pkg::t_in_item  r_item;
    logic               r_enabled;
    logic [CNT_W-1:0]   r_limit;
    logic [CNT_W-1:0]   r_count;
    logic [31:0]        r_hits;
    logic [31:0]        r_builds;
    logic               r_out_valid;
    lkc_pkg::t_out_item r_out;

    logic [CNT_W-1:0]   n_count;
    logic [31:0]        n_hits;
    logic [31:0]        n_builds;
    lkc_pkg::t_out_item n_out;

    logic                 w_in_xfer;
    logic                 w_do;
    lkc_pkg::t_key        w_key;
    lkc_pkg::t_cell_cmd   w_cmd;
    lkc_pkg::t_cell_cmd   w_cmd_gated;
    lkc_pkg::t_entry      w_entry [N];
    logic                 w_valid [N];
    lkc_pkg::t_cell_match w_match [N];
    logic                 w_found;
    logic                 w_full;
    logic [IDX_W-1:0]     w_pos;
    lkc_pkg::t_entry      w_hit_entry;
    lkc_pkg::t_entry      w_new_entry;
    logic [CNT_W-1:0]     w_rest;
    logic [CNT_W-1:0]     w_lim_m1;
    logic [CNT_W-1:0]     w_push_cnt;
    logic [5:0]           w_lim_raw;
    logic                 w_unused_valid;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_do       = (r_state == ST_EXEC) && (!r_out_valid || o_out.ready);

    assign w_key.key_hash    = i_in.payload.key_hash;
    assign w_key.path_length = i_in.payload.path_length;
    assign w_key.backend_id  = i_in.payload.backend_id;
    assign w_key.path_id     = i_in.payload.path_id;

    assign w_new_entry.key.key_hash    = r_item.key_hash;
    assign w_new_entry.key.path_length = r_item.path_length;
    assign w_new_entry.key.backend_id  = r_item.backend_id;
    assign w_new_entry.key.path_id     = r_item.path_id;
    assign w_new_entry.handle          = r_item.object_handle;

    // at most one slot can carry a given tag, so and-or selection is exact
    always_comb begin
        w_found     = 1'b0;
        w_full      = 1'b0;
        w_pos       = '0;
        w_hit_entry = '0;
        w_unused_valid = 1'b0;
        for (int i = 0; i < N; i++) begin
            w_found     = w_found | w_match[i].tag_hit;
            w_full      = w_full | (w_match[i].tag_hit & w_match[i].path_hit);
            w_pos       = w_pos | (IDX_W'(i) & {IDX_W{w_match[i].tag_hit}});
            w_hit_entry = w_hit_entry | (w_entry[i] & {$bits(lkc_pkg::t_entry){w_match[i].tag_hit}});
            w_unused_valid = w_unused_valid | w_valid[i];
        end
    end

    // new entry count: drop the tag collision, trim to limit-1, then push one
    assign w_rest     = r_count - CNT_W'(w_found);
    assign w_lim_m1   = r_limit - CNT_W'(1);
    assign w_push_cnt = ((w_rest < w_lim_m1) ? w_rest : w_lim_m1) + CNT_W'(1);

    always_comb begin
        w_cmd.kind    = lkc_pkg::CELL_HOLD;
        w_cmd.upto    = w_pos;
        w_cmd.new_cnt = r_count;
        w_cmd.front   = w_hit_entry;
        n_count       = r_count;
        n_hits        = r_hits;
        n_builds      = r_builds;
        n_out         = '0;
        unique case (r_item.func)
            lkc_pkg::FUNC_LOOKUP: begin
                if (r_enabled && w_full) begin
                    w_cmd.kind       = lkc_pkg::CELL_SHIFT;
                    n_hits           = lkc_pkg::sat_inc(r_hits);
                    n_out.hit        = 1'b1;
                    n_out.handle_out = w_hit_entry.handle;
                end
            end
            lkc_pkg::FUNC_INSERT: begin
                n_builds         = lkc_pkg::sat_inc(r_builds);
                n_out.handle_out = r_item.object_handle;
                if (r_enabled && (r_item.object_handle != '0)) begin
                    w_cmd.kind = lkc_pkg::CELL_SHIFT;
                    if (w_full) begin
                        w_cmd.front.handle = r_item.object_handle;
                    end else begin
                        // without a collision every slot moves down one place
                        w_cmd.upto    = w_found ? w_pos : IDX_W'(N - 1);
                        w_cmd.front   = w_new_entry;
                        w_cmd.new_cnt = w_push_cnt;
                        n_count       = w_push_cnt;
                    end
                end
            end
            lkc_pkg::FUNC_CLEAR: begin
                w_cmd.kind = lkc_pkg::CELL_CLEAR;
                n_count    = '0;
            end
            lkc_pkg::FUNC_ZERO: begin
                n_hits   = '0;
                n_builds = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_out.hit_count   = n_hits;
        n_out.build_count = n_builds;
        n_out.entry_count = 6'(n_count);
    end

    always_comb begin
        w_cmd_gated = w_cmd;
        if (!w_do) begin
            w_cmd_gated.kind = lkc_pkg::CELL_HOLD;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        lkc_pkg::t_entry w_left;
        if (g == 0) begin : g_head
            assign w_left = w_cmd_gated.front;
        end else begin : g_body
            assign w_left = w_entry[g-1];
        end
        lkc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_idx    (IDX_W'(g)),
            .i_cmp_en (w_in_xfer),
            .i_key    (w_key),
            .i_cmd    (w_cmd_gated),
            .i_left   (w_left),
            .o_entry  (w_entry[g]),
            .o_valid  (w_valid[g]),
            .o_match  (w_match[g])
        );
    end

    assign w_lim_raw = i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_enabled   <= 1'b1;
            r_limit     <= CNT_W'(lkc_pkg::LIMIT_RST);
            r_count     <= '0;
            r_hits      <= '0;
            r_builds    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lkc_pkg::REG_ENABLE: r_enabled <= i_cfg_data[0];
                    lkc_pkg::REG_LIMIT: begin
                        if (w_lim_raw == '0) begin
                            r_limit <= CNT_W'(1);
                        end else if (32'(w_lim_raw) > N) begin
                            r_limit <= CNT_W'(N);
                        end else begin
                            r_limit <= CNT_W'(w_lim_raw);
                        end
                    end
                    default: r_enabled <= r_enabled;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (w_do) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (w_do) begin
                r_count     <= n_count;
                r_hits      <= n_hits;
                r_builds    <= n_builds;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_item <= i_in.payload;
        end
        if (w_do) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

`default_nettype wire

/* sv/lkc_cell.sv */
`default_nettype none

// one slot of the recency chain; slot position is the recency rank
module lkc_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [lkc_pkg::IDX_W-1:0] i_idx,
    input  wire logic                      i_cmp_en,
    input  wire lkc_pkg::t_key             i_key,
    input  wire lkc_pkg::t_cell_cmd        i_cmd,
    input  wire lkc_pkg::t_entry           i_left,
    output lkc_pkg::t_entry                o_entry,
    output logic                           o_valid,
    output lkc_pkg::t_cell_match           o_match
);

    lkc_pkg::t_entry      r_entry;
    logic                 r_valid;
    lkc_pkg::t_cell_match r_match;
    logic                 w_tag_eq;
    logic                 w_take_left;

    assign w_tag_eq = (r_entry.key.key_hash == i_key.key_hash) &&
                      (r_entry.key.path_length == i_key.path_length) &&
                      (r_entry.key.backend_id == i_key.backend_id);

    assign w_take_left = (i_cmd.kind == lkc_pkg::CELL_SHIFT) && (i_idx <= i_cmd.upto);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= '0;
        end else begin
            if (i_cmp_en) begin
                r_match.tag_hit  <= r_valid && w_tag_eq;
                r_match.path_hit <= (r_entry.key.path_id == i_key.path_id);
            end
            case (i_cmd.kind)
                lkc_pkg::CELL_SHIFT: r_valid <= (32'(i_idx) < 32'(i_cmd.new_cnt));
                lkc_pkg::CELL_CLEAR: r_valid <= 1'b0;
                default:             r_valid <= r_valid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_left) begin
            r_entry <= i_left;
        end
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;
    assign o_match = r_match;

endmodule

`default_nettype wire

/* sv/lkc_checker.sv */
`default_nettype none

`include "lru_keyed_object_cache_assert.svh"

module lkc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_out_hit,
    input wire logic [15:0] i_out_handle,
    input wire logic [31:0] i_out_hits,
    input wire logic [5:0]  i_out_entries
);

    // a waiting response stays until taken
    `LKC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // one request in flight: no back-to-back transfers
    `LKC_ASSERT_NXT(a_in_gap, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    // only nonzero handles are ever stored
    `LKC_ASSERT_IMP(a_hit_handle, i_clk, i_rst_n, i_out_valid && i_out_hit, i_out_handle != '0)
    `LKC_ASSERT_IMP(a_hit_count, i_clk, i_rst_n, i_out_valid && i_out_hit, i_out_hits != '0)
    `LKC_ASSERT_IMP(a_count_max, i_clk, i_rst_n, i_out_valid, 32'(i_out_entries) <= lkc_pkg::ENTRIES)

endmodule

bind lru_keyed_object_cache lkc_checker u_lkc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_hit     (o_out.payload.hit),
    .i_out_handle  (o_out.payload.handle_out),
    .i_out_hits    (o_out.payload.hit_count),
    .i_out_entries (o_out.payload.entry_count)
);

`default_nettype wire

/* dv/tb_lru_keyed_object_cache.sv */
`timescale 1ns / 100ps

module tb_lru_keyed_object_cache;
    import lkc_pkg::*;

    localparam int          LONG_HOLD   = 300;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [1:0]  REG_SPARE2  = 2'd2;
    localparam logic [1:0]  REG_SPARE3  = 2'd3;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       cfg_we;
    logic [1:0] cfg_idx;
    logic [5:0] cfg_data;

    lkc_in_if  req_ch ();
    lkc_out_if rsp_ch ();

    lru_keyed_object_cache dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_ch),
        .o_out      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // mirror of the store
    logic        mirror_valid  [ENTRIES];
    t_key        mirror_key    [ENTRIES];
    logic [15:0] mirror_handle [ENTRIES];
    int          mirror_rank   [ENTRIES];
    logic [31:0] hits_seen;
    logic [31:0] builds_seen;
    logic        mirror_enabled;
    int          mirror_limit;

    t_in_item    queued_requests[$];
    t_out_item   pending_responses[$];
    t_key        key_pool[$];
    int          mismatches;
    int          send_gap_max;
    int          recv_gap_max;
    int          stall_ask;
    int          stall_seen;
    int          req_gap;
    int          rsp_gap;
    int          cycles;

    function automatic int live_entries();
        int n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (mirror_valid[i]) n++;
        return n;
    endfunction

    function automatic int find_tag(input t_in_item req);
        for (int i = 0; i < ENTRIES; i++)
            if (mirror_valid[i] && mirror_key[i].key_hash == req.key_hash &&
                mirror_key[i].path_length == req.path_length &&
                mirror_key[i].backend_id == req.backend_id)
                return i;
        return -1;
    endfunction

    function automatic void promote(input int slot);
        int r;
        r = mirror_rank[slot];
        for (int i = 0; i < ENTRIES; i++)
            if (mirror_valid[i] && mirror_rank[i] < r) mirror_rank[i]++;
        mirror_rank[slot] = 0;
    endfunction

    function automatic t_out_item predict_response(input t_in_item req);
        t_out_item resp;
        int        slot;
        int        free_slot;
        int        oldest;
        int        r;
        resp = '0;
        case (req.func)
            FUNC_LOOKUP: begin
                if (mirror_enabled) begin
                    slot = find_tag(req);
                    if (slot >= 0 && mirror_key[slot].path_id == req.path_id) begin
                        promote(slot);
                        if (hits_seen != '1) hits_seen++;
                        resp.hit        = 1'b1;
                        resp.handle_out = mirror_handle[slot];
                    end
                end
            end
            FUNC_INSERT: begin
                if (builds_seen != '1) builds_seen++;
                resp.handle_out = req.object_handle;
                if (mirror_enabled && req.object_handle != 16'h0) begin
                    slot = find_tag(req);
                    if (slot >= 0 && mirror_key[slot].path_id == req.path_id) begin
                        mirror_handle[slot] = req.object_handle;
                        promote(slot);
                    end else begin
                        // same tag, other path: the old entry goes away
                        if (slot >= 0) begin
                            r = mirror_rank[slot];
                            mirror_valid[slot] = 1'b0;
                            for (int i = 0; i < ENTRIES; i++)
                                if (mirror_valid[i] && mirror_rank[i] > r) mirror_rank[i]--;
                        end
                        while (live_entries() >= mirror_limit) begin
                            oldest = -1;
                            for (int i = 0; i < ENTRIES; i++)
                                if (mirror_valid[i] &&
                                    (oldest < 0 || mirror_rank[i] > mirror_rank[oldest]))
                                    oldest = i;
                            mirror_valid[oldest] = 1'b0;
                        end
                        free_slot = -1;
                        for (int i = 0; i < ENTRIES; i++)
                            if (!mirror_valid[i] && free_slot < 0) free_slot = i;
                        if (free_slot >= 0) begin
                            for (int i = 0; i < ENTRIES; i++)
                                if (mirror_valid[i]) mirror_rank[i]++;
                            mirror_valid[free_slot]              = 1'b1;
                            mirror_key[free_slot].key_hash       = req.key_hash;
                            mirror_key[free_slot].path_length    = req.path_length;
                            mirror_key[free_slot].backend_id     = req.backend_id;
                            mirror_key[free_slot].path_id        = req.path_id;
                            mirror_handle[free_slot]             = req.object_handle;
                            mirror_rank[free_slot]               = 0;
                        end
                    end
                end
            end
            FUNC_CLEAR: begin
                for (int i = 0; i < ENTRIES; i++) mirror_valid[i] = 1'b0;
            end
            default: begin
                hits_seen   = '0;
                builds_seen = '0;
            end
        endcase
        resp.hit_count   = hits_seen;
        resp.build_count = builds_seen;
        resp.entry_count = 6'(live_entries());
        return resp;
    endfunction

    function automatic t_in_item make_req(input logic [1:0] func, input t_key k,
                                          input logic [15:0] handle);
        t_in_item req;
        req.func          = func;
        req.key_hash      = k.key_hash;
        req.path_length   = k.path_length;
        req.backend_id    = k.backend_id;
        req.path_id       = k.path_id;
        req.object_handle = handle;
        return req;
    endfunction

    function automatic void build_pool(input int n);
        t_key k;
        key_pool.delete();
        for (int i = 0; i < n; i++) begin
            k.key_hash    = {$urandom, $urandom};
            k.path_length = 12'($urandom);
            k.backend_id  = 8'($urandom);
            k.path_id     = 16'($urandom);
            // some keys collide with an earlier one on the whole tag or on part of it
            if (i > 0 && $urandom_range(0, 3) == 0) begin
                k = key_pool[$urandom_range(0, i - 1)];
                case ($urandom_range(0, 3))
                    0, 1:    k.path_id     = k.path_id ^ 16'($urandom_range(1, 65535));
                    2:       k.path_length = k.path_length ^ 12'($urandom_range(1, 4095));
                    default: k.backend_id  = k.backend_id ^ 8'($urandom_range(1, 255));
                endcase
            end
            key_pool.push_back(k);
        end
    endfunction

    function automatic t_in_item random_req();
        t_in_item    req;
        t_key        k;
        logic [15:0] handle;
        int          pick;
        pick = $urandom_range(0, 99);
        k    = key_pool[$urandom_range(0, key_pool.size() - 1)];
        case ($urandom_range(0, 19))
            0, 1:    handle = 16'h0;
            2:       handle = 16'hFFFF;
            default: handle = 16'($urandom_range(1, 65535));
        endcase
        if (pick < 50)      req = make_req(FUNC_LOOKUP, k, handle);
        else if (pick < 88) req = make_req(FUNC_INSERT, k, handle);
        else if (pick < 91) req = make_req(FUNC_CLEAR, k, handle);
        else if (pick < 93) req = make_req(FUNC_ZERO, k, handle);
        else begin
            k.key_hash    = {$urandom, $urandom};
            k.path_length = 12'($urandom);
            k.backend_id  = 8'($urandom);
            k.path_id     = 16'($urandom);
            req = make_req(2'($urandom_range(0, 3)), k, 16'($urandom));
        end
        return req;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid   <= 1'b0;
            req_ch.payload <= '0;
            req_gap        <= 0;
        end else if (!(req_ch.valid && !req_ch.ready)) begin
            if (req_ch.valid) pending_responses.push_back(predict_response(req_ch.payload));
            if (req_gap != 0) begin
                req_gap      <= req_gap - 1;
                req_ch.valid <= 1'b0;
            end else if (queued_requests.size() != 0) begin
                req_ch.payload <= queued_requests.pop_front();
                req_ch.valid   <= 1'b1;
                req_gap        <= $urandom_range(0, send_gap_max);
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    task automatic check_response(input t_out_item got);
        t_out_item want;
        if (pending_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response with nothing pending: %p", got);
        end else begin
            want = pending_responses.pop_front();
            if (got.hit !== want.hit || got.handle_out !== want.handle_out ||
                got.hit_count !== want.hit_count || got.build_count !== want.build_count ||
                got.entry_count !== want.entry_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: expected %p, got %p", $realtime, want, got);
            end
        end
    endtask

    // response monitor and ready control
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rsp_gap      <= 0;
            stall_seen   <= 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) check_response(rsp_ch.payload);
            if (stall_seen != stall_ask) begin
                stall_seen   <= stall_ask;
                rsp_ch.ready <= 1'b0;
                rsp_gap      <= LONG_HOLD;
            end else if (rsp_gap != 0) begin
                rsp_gap      <= rsp_gap - 1;
                rsp_ch.ready <= 1'b0;
            end else if (rsp_ch.valid && rsp_ch.ready) begin
                automatic int draw = $urandom_range(0, recv_gap_max);
                rsp_gap      <= draw;
                rsp_ch.ready <= (draw == 0);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        do @(negedge i_clk);
        while (queued_requests.size() != 0 || req_ch.valid || pending_responses.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [5:0] data);
        int lim;
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == REG_ENABLE) begin
            mirror_enabled = data[0];
        end else if (idx == REG_LIMIT) begin
            lim = data;
            if (lim == 0) lim = 1;
            if (lim > ENTRIES) lim = ENTRIES;
            mirror_limit = lim;
        end
    endtask

    task automatic run_phase(input logic [5:0] en_data, input logic [5:0] lim_data,
                             input int n, input int pool_n, input int smax, input int rmax,
                             input bit spare, input bit squeeze);
        wait_drained();
        write_cfg(REG_ENABLE, en_data);
        write_cfg(REG_LIMIT, lim_data);
        if (spare) begin
            write_cfg(REG_SPARE2, 6'($urandom));
            write_cfg(REG_SPARE3, 6'($urandom));
        end
        @(negedge i_clk);
        send_gap_max = smax;
        recv_gap_max = rmax;
        build_pool(pool_n);
        for (int i = 0; i < n; i++) queued_requests.push_back(random_req());
        if (squeeze) stall_ask++;
    endtask

    initial begin
        t_key key_zero;
        t_key key_ones;
        t_key key_ones_alt;
        t_key key_mid;
        t_key key_zero_len;

        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = REG_ENABLE;
        cfg_data       = '0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        cycles         = 0;
        mismatches     = 0;
        stall_ask      = 0;
        send_gap_max   = 14;
        recv_gap_max   = 14;
        hits_seen      = '0;
        builds_seen    = '0;
        mirror_enabled = 1'b1;
        mirror_limit   = LIMIT_RST;
        for (int i = 0; i < ENTRIES; i++) begin
            mirror_valid[i]  = 1'b0;
            mirror_key[i]    = '0;
            mirror_handle[i] = '0;
            mirror_rank[i]   = 0;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        key_zero                 = '0;
        key_ones                 = '1;
        key_ones_alt             = '1;
        key_ones_alt.path_id     = 16'h0;
        key_mid                  = '{key_hash: 64'h5A5A_0F0F_C3C3_9696, path_length: 12'h800,
                                     backend_id: 8'h80, path_id: 16'h8001};
        key_zero_len             = '0;
        key_zero_len.path_length = 12'h001;

        queued_requests.push_back(make_req(FUNC_LOOKUP, key_zero, 16'h0));
        queued_requests.push_back(make_req(FUNC_INSERT, key_zero, 16'h0001));
        queued_requests.push_back(make_req(FUNC_LOOKUP, key_zero, 16'h0));
        queued_requests.push_back(make_req(FUNC_INSERT, key_ones, 16'hFFFF));
        queued_requests.push_back(make_req(FUNC_LOOKUP, key_ones, 16'hFFFF));
        // same tag, other path must miss
        queued_requests.push_back(make_req(FUNC_LOOKUP, key_ones_alt, 16'h0));
        // failed build stores nothing
        queued_requests.push_back(make_req(FUNC_INSERT, key_mid, 16'h0));
        queued_requests.push_back(make_req(FUNC_LOOKUP, key_mid, 16'h0));
        queued_requests.push_back(make_req(FUNC_INSERT, key_ones_alt, 16'h1234));
        queued_requests.push_back(make_req(FUNC_LOOKUP, key_ones, 16'h0));
        queued_requests.push_back(make_req(FUNC_LOOKUP, key_ones_alt, 16'h0));
        queued_requests.push_back(make_req(FUNC_INSERT, key_zero, 16'h8000));
        queued_requests.push_back(make_req(FUNC_LOOKUP, key_zero, 16'h0));
        queued_requests.push_back(make_req(FUNC_LOOKUP, key_zero_len, 16'h0));
        queued_requests.push_back(make_req(FUNC_ZERO, key_mid, 16'hFFFF));
        queued_requests.push_back(make_req(FUNC_LOOKUP, key_zero, 16'h0));
        queued_requests.push_back(make_req(FUNC_CLEAR, key_ones, 16'hFFFF));
        queued_requests.push_back(make_req(FUNC_LOOKUP, key_zero, 16'h0));
        queued_requests.push_back(make_req(FUNC_INSERT, key_mid, 16'h5A5A));
        queued_requests.push_back(make_req(FUNC_LOOKUP, key_mid, 16'h0));

        // full size with more keys than slots, and a long receiver hold
        run_phase(6'h01, 6'd32, 200, 40, 14, 14, 1'b0, 1'b1);
        // a limit of zero keeps one entry
        run_phase(6'h3F, 6'd0, 60, 4, 0, 0, 1'b1, 1'b0);
        run_phase(6'h01, 6'd5, 150, 8, 14, 0, 1'b0, 1'b0);
        // fill a large limit, then lower it with entries still held
        run_phase(6'h01, 6'd20, 120, 24, 0, 14, 1'b0, 1'b0);
        run_phase(6'h01, 6'd3, 100, 24, 3, 3, 1'b1, 1'b0);
        // store bypassed; limit write above the size
        run_phase(6'h3E, 6'd63, 80, 12, 14, 14, 1'b0, 1'b0);
        run_phase(6'h01, 6'd63, 100, 48, 0, 0, 1'b0, 1'b1);
        run_phase(6'h01, 6'd33, 80, 16, 14, 14, 1'b1, 1'b0);
        run_phase(6'h3F, 6'd12, 150, 20, 5, 14, 1'b0, 1'b0);
        run_phase(6'h00, 6'd1, 40, 6, 14, 3, 1'b0, 1'b0);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_responses.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+sv
sv/lkc_pkg.sv
sv/lkc_in_if.sv
sv/lkc_out_if.sv
sv/lkc_cell.sv
sv/lru_keyed_object_cache.sv
sv/lkc_checker.sv
dv/tb_lru_keyed_object_cache.sv
